@@ design/lesm_pkg.sv @@
// Shared types and constants for the latency event series monitor.
package lesm_pkg;

   localparam int RING_LEN_DEF   = 128;
   localparam int NUM_EVENTS_DEF = 16;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_ANALYZE = 2'd1,
      CMD_RESET   = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic load;       // capture request word
      logic clr_start;  // begin ring clear for new series
      logic clr_step;   // clear one slot
      logic add_rd;     // read previous slot
      logic add_wr;     // finish add
      logic scan_start; // begin pass
      logic scan_step;  // read/accumulate one slot
      logic div_start;  // start division
      logic div_step;   // one division iteration
      logic pass2;      // selects deviation pass
      logic fin_avg;    // latch average
      logic fin_out;    // build analyze result
      logic do_reset;   // execute reset and build result
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    ev_ok;
      logic    exists;
      logic    clr_last;
      logic    div_done;
   } dp_sts_type;

endpackage

@@ design/lesm_datapath.sv @@
// Datapath: series state, slot memories, accumulators and shared divider.
module lesm_datapath
   import lesm_pkg::*;
#(
   parameter int RING_LEN   = RING_LEN_DEF,
   parameter int NUM_EVENTS = NUM_EVENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_sts_type         sts,
   input  logic [1:0]         req_command,
   input  logic [3:0]         req_event_id,
   input  logic [31:0]        req_latency_ms,
   input  logic [31:0]        req_current_time,
   input  logic               req_reset_all,
   output logic               rsp_series_present,
   output logic [7:0]         rsp_sample_count,
   output logic [31:0]        rsp_average,
   output logic [31:0]        rsp_minimum,
   output logic [31:0]        rsp_maximum,
   output logic [31:0]        rsp_mean_abs_dev,
   output logic [31:0]        rsp_period_s,
   output logic [31:0]        rsp_all_time_high,
   output logic [4:0]         rsp_reset_count
);
   localparam int RW = $clog2(RING_LEN);
   localparam int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
   localparam int DEPTH = NUM_EVENTS << RW;
   localparam int AW = RW + EW;
   localparam int NW = $clog2(RING_LEN + 1);
   localparam int SW = 32 + NW;

   logic [31:0] slot_time_mem [DEPTH];
   logic [31:0] slot_lat_mem  [DEPTH];
   logic [NUM_EVENTS-1:0] exists_ff;
   logic [RW-1:0] widx_ff [NUM_EVENTS];
   logic [31:0] smax_ff [NUM_EVENTS];

   logic [1:0]    cmd_ff;
   logic [3:0]    ev_ff;
   logic [31:0]   lat_ff, now_ff;
   logic          all_ff;
   logic [RW-1:0] ptr_ff;
   logic [31:0]   rd_time_ff, rd_lat_ff;
   logic          rd_vld_ff;
   logic [NW-1:0] n_ff;
   logic [31:0]   mn_ff, mx_ff, old_ff, avg_ff;
   logic [SW-1:0] sum_ff;
   logic [SW-1:0] rem_ff, quo_ff;
   logic [5:0]    dcnt_ff;

   logic [EW-1:0] ev_idx;
   logic [RW-1:0] prev_idx;
   logic [RW-1:0] next_idx;
   logic [AW-1:0] rd_addr;
   logic          ev_ok;
   logic          show_stats;
   logic          have_samples;

   assign ev_idx = EW'(ev_ff);
   assign ev_ok  = ({28'd0, ev_ff} < 32'(NUM_EVENTS));
   assign prev_idx = (widx_ff[ev_idx] == '0) ? RW'(RING_LEN - 1) : widx_ff[ev_idx] - RW'(1);
   assign next_idx = (widx_ff[ev_idx] == RW'(RING_LEN - 1)) ? '0 : widx_ff[ev_idx] + RW'(1);
   assign rd_addr = {ev_idx, (cmd.add_rd ? prev_idx : ptr_ff)};
   assign show_stats   = cmd.fin_out && ev_ok && exists_ff[ev_idx];
   assign have_samples = show_stats && (n_ff != '0);

   assign sts.cmd       = cmd_type'(cmd_ff);
   assign sts.ev_ok     = ev_ok;
   assign sts.exists    = exists_ff[ev_idx];
   assign sts.clr_last  = (ptr_ff == RW'(RING_LEN - 1));
   assign sts.div_done  = (dcnt_ff == 6'd0);

   // Absolute deviation of the slot just read.
   logic [31:0] adev;
   assign adev = (avg_ff >= rd_lat_ff) ? avg_ff - rd_lat_ff : rd_lat_ff - avg_ff;

   // Reset count.
   logic [4:0] rcnt;
   always_comb begin
      rcnt = '0;
      for (int e = 0; e < NUM_EVENTS; e++) begin
         if ((all_ff || ({28'd0, ev_ff} == 32'(e))) && exists_ff[e]) rcnt = rcnt + 5'd1;
      end
   end

   // Restoring division step.
   logic [SW:0] trial;
   logic [SW-1:0] rem_sh;
   assign rem_sh = {rem_ff[SW-2:0], quo_ff[SW-1]};
   assign trial  = {1'b0, rem_sh} - {{(SW+1-NW){1'b0}}, n_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         ev_ff  <= req_event_id;
         lat_ff <= req_latency_ms;
         now_ff <= req_current_time;
         all_ff <= req_reset_all;
      end
      if (cmd.clr_start || cmd.scan_start) ptr_ff <= '0;
      else if (cmd.clr_step || cmd.scan_step) ptr_ff <= ptr_ff + RW'(1);
      if (cmd.clr_step) begin
         slot_time_mem[{ev_idx, ptr_ff}] <= '0;
         slot_lat_mem[{ev_idx, ptr_ff}]  <= '0;
      end
      rd_time_ff <= slot_time_mem[rd_addr];
      rd_lat_ff  <= slot_lat_mem[rd_addr];
      rd_vld_ff  <= cmd.scan_step;
      if (cmd.add_wr) begin
         if (rd_time_ff == now_ff) begin
            if (lat_ff > rd_lat_ff) slot_lat_mem[{ev_idx, prev_idx}] <= lat_ff;
         end else begin
            slot_time_mem[{ev_idx, widx_ff[ev_idx]}] <= now_ff;
            slot_lat_mem[{ev_idx, widx_ff[ev_idx]}]  <= lat_ff;
         end
      end
      if (cmd.scan_start) begin
         sum_ff <= '0;
         if (!cmd.pass2) begin
            n_ff <= '0; mn_ff <= '0; mx_ff <= '0; old_ff <= '0;
         end
      end else if (rd_vld_ff && rd_time_ff != 32'd0) begin
         if (!cmd.pass2) begin
            n_ff <= n_ff + NW'(1);
            sum_ff <= sum_ff + SW'(rd_lat_ff);
            if (n_ff == '0 || rd_lat_ff < mn_ff) mn_ff <= rd_lat_ff;
            if (n_ff == '0 || rd_lat_ff > mx_ff) mx_ff <= rd_lat_ff;
            if (old_ff == 32'd0 || rd_time_ff < old_ff) old_ff <= rd_time_ff;
         end else begin
            sum_ff <= sum_ff + SW'(adev);
         end
      end
      if (cmd.div_start) begin
         rem_ff <= '0; quo_ff <= sum_ff; dcnt_ff <= 6'(SW);
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - 6'd1;
         if (!trial[SW]) begin
            rem_ff <= trial[SW-1:0]; quo_ff <= {quo_ff[SW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh; quo_ff <= {quo_ff[SW-2:0], 1'b0};
         end
      end
      if (cmd.fin_avg) avg_ff <= quo_ff[31:0];
      if (cmd.fin_out || cmd.do_reset) begin
         rsp_series_present <= show_stats;
         rsp_all_time_high  <= show_stats ? smax_ff[ev_idx] : '0;
         rsp_sample_count   <= have_samples ? 8'(n_ff) : '0;
         rsp_average        <= have_samples ? avg_ff : '0;
         rsp_minimum        <= have_samples ? mn_ff : '0;
         rsp_maximum        <= have_samples ? mx_ff : '0;
         rsp_mean_abs_dev   <= have_samples ? quo_ff[31:0] : '0;
         rsp_period_s       <= !have_samples ? '0 :
                               (now_ff == old_ff) ? 32'd1 : now_ff - old_ff;
         rsp_reset_count    <= cmd.do_reset ? rcnt : '0;
      end
   end

   logic [NW-1:0] n_keep_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         exists_ff <= '0;
         for (int e = 0; e < NUM_EVENTS; e++) begin
            widx_ff[e] <= '0; smax_ff[e] <= '0;
         end
      end else begin
         if (cmd.clr_start) begin
            exists_ff[ev_idx] <= 1'b1;
            widx_ff[ev_idx] <= '0;
            smax_ff[ev_idx] <= '0;
         end
         if (cmd.add_wr) begin
            if (lat_ff > smax_ff[ev_idx]) smax_ff[ev_idx] <= lat_ff;
            if (rd_time_ff != now_ff) widx_ff[ev_idx] <= next_idx;
         end
         if (cmd.do_reset) begin
            for (int e = 0; e < NUM_EVENTS; e++) begin
               if (all_ff || ({28'd0, ev_ff} == 32'(e))) exists_ff[e] <= 1'b0;
            end
         end
      end
      n_keep_ff <= n_ff;
   end

   unused_n: assert property (@(posedge clock) disable iff (reset)
      cmd.add_wr |-> !cmd.clr_step)
      else $error("write collision");
   div_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> dcnt_ff != 6'd0)
      else $error("divider overrun");
   cnt_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.pass2 && rd_vld_ff |-> n_ff == n_keep_ff)
      else $error("count changed in second pass");
endmodule

@@ design/lesm_ctrl.sv @@
// Controller state machine sequencing add, analyze and reset.
module lesm_ctrl
   import lesm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DEC, S_CLR, S_ARD, S_AWAIT, S_AWR,
      S_SCAN1, S_DRN1, S_LD1, S_DIV1, S_AVG, S_SCAN2, S_DRN2, S_LD2, S_DIV2, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid && req_ready;
            if (cmd.load) state_in = S_DEC;
         end
         S_DEC: begin
            unique case (sts.cmd)
               CMD_ADD: begin
                  if (!sts.ev_ok) state_in = S_IDLE;
                  else if (!sts.exists) begin
                     cmd.clr_start = 1'b1; state_in = S_CLR;
                  end else state_in = S_ARD;
               end
               CMD_ANALYZE: begin
                  if (sts.ev_ok && sts.exists) begin
                     cmd.scan_start = 1'b1; state_in = S_SCAN1;
                  end else begin
                     cmd.fin_out = 1'b1; state_in = S_OUT;
                  end
               end
               CMD_RESET: begin
                  cmd.do_reset = 1'b1; state_in = S_OUT;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_ARD;
         end
         S_ARD:   begin cmd.add_rd = 1'b1; state_in = S_AWAIT; end
         S_AWAIT: begin cmd.add_rd = 1'b1; state_in = S_AWR; end
         S_AWR:   begin cmd.add_wr = 1'b1; state_in = S_IDLE; end
         S_SCAN1: begin
            cmd.scan_step = 1'b1;
            if (sts.clr_last) state_in = S_DRN1;
         end
         S_DRN1: state_in = S_LD1;
         S_LD1: begin
            cmd.div_start = 1'b1; state_in = S_DIV1;
         end
         S_DIV1: begin
            cmd.div_step = !sts.div_done;
            if (sts.div_done) state_in = S_AVG;
         end
         S_AVG: begin
            cmd.fin_avg = 1'b1; cmd.scan_start = 1'b1; cmd.pass2 = 1'b1; state_in = S_SCAN2;
         end
         S_SCAN2: begin
            cmd.pass2 = 1'b1;
            cmd.scan_step = 1'b1;
            if (sts.clr_last) state_in = S_DRN2;
         end
         S_DRN2: begin
            cmd.pass2 = 1'b1; state_in = S_LD2;
         end
         S_LD2: begin
            cmd.div_start = 1'b1; state_in = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_step = !sts.div_done;
            if (sts.div_done) begin cmd.fin_out = 1'b1; state_in = S_OUT; end
         end
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   one_job: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted while busy");
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");
   out_gate: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> !rsp_valid_ff)
      else $error("result overwritten");
endmodule

@@ design/latency_event_series_monitor_top.sv @@
// An add that creates a series first clears all RING_LEN slots of that series.
// An analyze makes two ring passes over the slot memory port and two divisions
// in the shared serial divider.
// One word is in work at a time; the next is taken once that work ends and any result has left.
// Reset is synchronous and clears the series flags, wrap indexes and maxima;
// the slot memories are cleared per series when that series is created.
// Top level of the latency event series monitor.
module latency_event_series_monitor_top
   import lesm_pkg::*;
#(
   parameter int RING_LEN   = RING_LEN_DEF,
   parameter int NUM_EVENTS = NUM_EVENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_event_id,
   input  logic [31:0] req_latency_ms,
   input  logic [31:0] req_current_time,
   input  logic        req_reset_all,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_series_present,
   output logic [7:0]  rsp_sample_count,
   output logic [31:0] rsp_average,
   output logic [31:0] rsp_minimum,
   output logic [31:0] rsp_maximum,
   output logic [31:0] rsp_mean_abs_dev,
   output logic [31:0] rsp_period_s,
   output logic [31:0] rsp_all_time_high,
   output logic [4:0]  rsp_reset_count
);
   dp_cmd_type cmd;
   dp_sts_type sts;

   lesm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   lesm_datapath #(.RING_LEN(RING_LEN), .NUM_EVENTS(NUM_EVENTS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_command, .req_event_id, .req_latency_ms, .req_current_time, .req_reset_all,
      .rsp_series_present, .rsp_sample_count, .rsp_average, .rsp_minimum,
      .rsp_maximum, .rsp_mean_abs_dev, .rsp_period_s, .rsp_all_time_high,
      .rsp_reset_count
   );
endmodule
